@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Clock and reset are taken from the enclosing module (clk_i, rst_ni).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, idle while reset is held.
`define PLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define PLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/plt_pkg.sv @@
package plt_pkg;

  localparam logic OP_ANNOUNCE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  typedef enum logic [2:0] {
    ST_REFRESHED  = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_FULL       = 3'd2,
    ST_REJECTED   = 3'd3,
    ST_TICK_IDLE  = 3'd4,
    ST_TICK_SWEPT = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CHK,
    S_RDL,
    S_MOVE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] prefix_high;
    logic [63:0] prefix_low;
    logic [31:0] last_seen;
    logic [30:0] lease;
  } entry_t;

endpackage

@@ rtl/core/participant_lease_table.sv @@
// Sequence: an announce reads and compares held entries from slot zero up to a hit or the
//   last held entry; a rejected announce, an empty table or an idle tick skips the walk; a sweep
//   checks every held entry and refills each expired slot from the last entry. Each read is registered.
// Throughput: one request at a time; the next is taken in the cycle after the result is loaded,
//   even while that result waits.
// Reset: count, broadcast time, output valid clear; interval 3; entry memory left as is.
`include "assert_macros.svh"

module participant_lease_table import plt_pkg::*; #(
  parameter int MAX_PARTICIPANTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] now_seconds_i,
  input  logic [31:0] prefix_high_i,
  input  logic [63:0] prefix_low_i,
  input  logic [30:0] lease_seconds_i,
  input  logic        encoding_ok_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  entry_count_o,
  output logic [4:0]  removed_count_o,
  output logic        broadcast_due_o
);

  // Slot index and entry count widths follow the table depth.
  localparam int IW = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;
  localparam int CW = $clog2(MAX_PARTICIPANTS + 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [31:0]     last_bcast_q, last_bcast_d;
  logic [15:0]     interval_q;
  logic            out_valid_q, out_valid_d;

  // Request held for the whole walk.
  logic            opcode_q;
  logic [31:0]     now_q;
  logic [31:0]     ph_q;
  logic [63:0]     pl_q;
  logic [30:0]     lease_q;
  logic            enc_q;

  // Walk position and result being built.
  logic [IW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   removed_q, removed_d;
  status_e         res_status_q, res_status_d;
  logic [IW-1:0]   res_slot_q, res_slot_d;

  // Output register.
  status_e         out_status_q;
  logic [IW-1:0]   out_slot_q;
  logic [CW-1:0]   out_count_q;
  logic [CW-1:0]   out_removed_q;

  // Entry memory: one write and one registered read per cycle.
  entry_t          mem_q [MAX_PARTICIPANTS];
  entry_t          rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [IW-1:0]   mem_raddr;

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic            in_accept;
  logic            out_free;
  logic            hit;
  logic [31:0]     age;
  logic            expired;
  logic [CW-1:0]   idx_inc;
  logic            at_end;
  logic            full;
  logic            empty;
  logic [31:0]     bcast_diff;
  logic            due;
  logic [CW-1:0]   count_m1;
  logic [IW-1:0]   last_idx;
  logic            move_more;
  entry_t          item_entry;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // Prefix match against the entry just read.
  assign hit = (rdata_q.prefix_high == ph_q) && (rdata_q.prefix_low == pl_q);

  // Age is signed modulo 2^32: a stored second in the future never expires.
  assign age     = now_q - rdata_q.last_seen;
  assign expired = ~age[31] && (age[30:0] > rdata_q.lease);

  assign idx_inc  = CW'(idx_q) + CW'(1);
  assign at_end   = (idx_inc >= count_q);
  assign full     = (count_q == CW'(MAX_PARTICIPANTS));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CW'(1);
  assign last_idx = count_m1[IW-1:0];
  // After a move the count drops by one; examine the same slot again if it is still held.
  assign move_more = (CW'(idx_q) < count_m1);

  assign bcast_diff = now_q - last_bcast_q;
  assign due        = ~bcast_diff[31] && (bcast_diff >= {16'b0, interval_q});

  assign item_entry = '{prefix_high: ph_q, prefix_low: pl_q, last_seen: now_q, lease: lease_q};

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_START;
      end
      S_START: begin
        if (opcode_q == OP_ANNOUNCE) begin
          state_d = (!enc_q || empty) ? S_DONE : S_RD;
        end else begin
          state_d = (!due || empty) ? S_DONE : S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (opcode_q == OP_ANNOUNCE) begin
          state_d = (hit || at_end) ? S_DONE : S_RD;
        end else begin
          priority if (expired) state_d = S_RDL;
          else if (at_end)      state_d = S_DONE;
          else                  state_d = S_RD;
        end
      end
      S_RDL:  state_d = S_MOVE;
      S_MOVE: state_d = move_more ? S_RD : S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    count_d      = count_q;
    last_bcast_d = last_bcast_q;
    idx_d        = idx_q;
    removed_d    = removed_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = item_entry;
    mem_raddr    = idx_q;
    out_valid_d  = out_valid_q & ~out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        idx_d     = '0;
        removed_d = '0;
      end
      S_START: begin
        res_slot_d = '0;
        if (opcode_q == OP_ANNOUNCE) begin
          if (!enc_q) begin
            res_status_d = ST_REJECTED;
          end else if (empty) begin
            // Empty table: append straight into slot zero.
            mem_we       = 1'b1;
            mem_waddr    = '0;
            count_d      = count_q + CW'(1);
            res_status_d = ST_INSERTED;
          end
        end else begin
          if (!due) begin
            res_status_d = ST_TICK_IDLE;
          end else begin
            last_bcast_d = now_q;
            res_status_d = ST_TICK_SWEPT;
          end
        end
      end
      S_RD: ;
      S_CHK: begin
        if (opcode_q == OP_ANNOUNCE) begin
          if (hit) begin
            // Refresh last-seen only; keep the stored lease.
            mem_we       = 1'b1;
            mem_waddr    = idx_q;
            mem_wdata    = rdata_q;
            mem_wdata.last_seen = now_q;
            res_status_d = ST_REFRESHED;
            res_slot_d   = idx_q;
          end else if (at_end) begin
            if (full) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = count_q[IW-1:0];
              count_d      = count_q + CW'(1);
              res_status_d = ST_INSERTED;
              res_slot_d   = count_q[IW-1:0];
            end
          end else begin
            idx_d = idx_inc[IW-1:0];
          end
        end else begin
          if (!expired && !at_end) idx_d = idx_inc[IW-1:0];
        end
      end
      S_RDL: begin
        // Fetch the last entry to fill the expired slot.
        mem_raddr = last_idx;
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rdata_q;
        count_d   = count_m1;
        removed_d = removed_q + CW'(1);
      end
      S_DONE: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      last_bcast_q <= '0;
      interval_q   <= 16'd3;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      last_bcast_q <= last_bcast_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) interval_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q <= opcode_i;
      now_q    <= now_seconds_i;
      ph_q     <= prefix_high_i;
      pl_q     <= prefix_low_i;
      lease_q  <= lease_seconds_i;
      enc_q    <= encoding_ok_i;
    end
    idx_q        <= idx_d;
    removed_q    <= removed_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    // Load the result once the output register is free.
    if (state_q == S_DONE && out_free) begin
      out_status_q  <= res_status_q;
      out_slot_q    <= res_slot_q;
      out_count_q   <= count_q;
      out_removed_q <= removed_q;
    end
  end

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Outputs: slot and counts carry their low bits only.
  // ---------------------------------------------------------------------------
  logic [IW+3:0] slot_ext;
  logic [CW+4:0] count_ext;
  logic [CW+4:0] removed_ext;

  assign slot_ext    = {4'b0, out_slot_q};
  assign count_ext   = {5'b0, out_count_q};
  assign removed_ext = {5'b0, out_removed_q};

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = slot_ext[3:0];
  assign entry_count_o   = count_ext[4:0];
  assign removed_count_o = removed_ext[4:0];
  assign broadcast_due_o = (out_status_q == ST_TICK_SWEPT);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PLT_ASSERT(a_count_bound, count_q <= CW'(MAX_PARTICIPANTS), "entry count above depth")
  `PLT_ASSERT(a_read_held, (state_q == S_RD) |-> (CW'(idx_q) < count_q), "read of a slot not held")
  `PLT_ASSERT(a_move_drops, (state_q == S_MOVE) |=> (count_q == $past(count_m1)), "move did not drop count")
  `PLT_ASSERT(a_write_in_range, mem_we |-> (CW'(mem_waddr) <= count_q), "write beyond table end")

endmodule
